// ----- rtl/core/rct_pkg.sv -----
`timescale 1ns / 1ps

package rct_pkg;

   // Table geometry and count width
   localparam int ENTRIES_PER_TABLE = 64;
   localparam int COUNT_BITS        = 32;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int SLOT_W            = IDX_W + 1;
   localparam int SLOTS             = 2 ** SLOT_W;
   localparam int KEY_W             = 64;
   localparam int PIN_W             = 32;

   // Command codes; the unused code acts as a query
   localparam logic [1:0] CMD_INCR  = 2'd0;
   localparam logic [1:0] CMD_DECR  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [SLOT_W-1:0]     slot_type;

   typedef struct packed {
      logic [1:0]       command;
      logic             table_select;
      logic [KEY_W-1:0] object_address;
   } req_type;

   typedef struct packed {
      logic [PIN_W-1:0] pin_count;
      logic             found;
      logic             table_full;
   } rsp_type;

   // Write port of the key and count stores
   typedef struct packed {
      logic             en;
      logic             key_en;
      slot_type         addr;
      logic [KEY_W-1:0] key;
      count_type        count;
   } store_wr_type;

   // Registered read data of the stores
   typedef struct packed {
      logic [KEY_W-1:0] key;
      count_type        count;
   } store_rd_type;

   // Clamp a count to the reported pin count width
   function automatic logic [PIN_W-1:0] to_pin_count(input count_type c);
      logic [63:0] wide;
      wide = 64'(c);
      if (wide > 64'h0000_0000_FFFF_FFFF) begin
         return '1;
      end
      return wide[PIN_W-1:0];
   endfunction

endpackage

// ----- rtl/core/reference_count_table.sv -----
`timescale 1ns / 1ps

// Channel   Ports                         Transfer
// request   start, busy, req_data         start high and busy low at a rising edge
// result    rsp_strobe, rsp_data          rsp_strobe high for one cycle, always taken
//
// A request scans its table one slot per cycle through a single key compare,
// then passes the shared count step unit in the update state; busy stays high
// through the scan and the update, and the scan ends early when the key hits.
// The result strobe is high in the first cycle that busy is low.
// Reset is synchronous and empties both tables at once through the valid bits.
// The receiver cannot stall; results are never held.

module reference_count_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rct_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rct_pkg::rsp_type rsp_data
);

   rct_pkg::slot_type     rd_addr;
   rct_pkg::store_rd_type rd_data;
   rct_pkg::store_wr_type wr;

   rct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr         (wr)
   );

   rct_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- rtl/core/rct_store.sv -----
`timescale 1ns / 1ps

module rct_store (
   input  logic                  clock,
   input  rct_pkg::store_wr_type wr,
   input  rct_pkg::slot_type     rd_addr,
   output rct_pkg::store_rd_type rd_data
);

   logic [rct_pkg::KEY_W-1:0] key_mem   [rct_pkg::SLOTS];
   rct_pkg::count_type        count_mem [rct_pkg::SLOTS];
   rct_pkg::store_rd_type     rd_ff;

   // Write key on allocation and count on every update; read both through a register
   always_ff @(posedge clock) begin
      if (wr.en && wr.key_en) begin
         key_mem[wr.addr] <= wr.key;
      end
      if (wr.en) begin
         count_mem[wr.addr] <= wr.count;
      end
      rd_ff.key   <= key_mem[rd_addr];
      rd_ff.count <= count_mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ----- rtl/core/rct_ctrl.sv -----
`timescale 1ns / 1ps

module rct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rct_pkg::req_type      req,
   output logic                  busy,
   output logic                  rsp_strobe,
   output rct_pkg::rsp_type      rsp,
   output rct_pkg::slot_type     rd_addr,
   input  rct_pkg::store_rd_type rd_data,
   output rct_pkg::store_wr_type wr
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   localparam rct_pkg::idx_type   LAST_IDX  = rct_pkg::IDX_W'(rct_pkg::ENTRIES_PER_TABLE - 1);
   localparam rct_pkg::count_type COUNT_MAX = '1;
   localparam rct_pkg::count_type COUNT_ONE = rct_pkg::COUNT_BITS'(1);

   state_type          state_ff, state_in;
   rct_pkg::req_type   req_ff, req_in;
   rct_pkg::idx_type   idx_ff, idx_in;
   logic               issue_done_ff, issue_done_in;
   logic               cmp_vld_ff, cmp_vld_in;
   rct_pkg::idx_type   cmp_idx_ff, cmp_idx_in;
   logic               free_vld_ff, free_vld_in;
   rct_pkg::idx_type   free_idx_ff, free_idx_in;
   logic               hit_ff, hit_in;
   rct_pkg::idx_type   hit_idx_ff, hit_idx_in;
   rct_pkg::count_type count_ff, count_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rct_pkg::rsp_type   rsp_ff, rsp_in;
   logic [rct_pkg::ENTRIES_PER_TABLE-1:0] valid_ff [2];

   logic               tbl;
   logic               key_match;
   logic               last_cmp;
   logic               is_dec;
   rct_pkg::count_type step;
   rct_pkg::count_type incr_val;
   logic               alloc;
   logic               release_slot;

   assign tbl     = req_ff.table_select;
   assign rd_addr = {tbl, idx_ff};

   // Shared compare: one stored key against the request key per cycle
   assign key_match = cmp_vld_ff && valid_ff[tbl][cmp_idx_ff]
                      && (rd_data.key == req_ff.object_address);
   assign last_cmp  = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);

   // Shared step unit: plus or minus one
   assign is_dec   = (req_ff.command == rct_pkg::CMD_DECR);
   assign step     = count_ff + {{(rct_pkg::COUNT_BITS-1){is_dec}}, 1'b1};
   assign incr_val = (count_ff == COUNT_MAX) ? count_ff : step;

   // Sequence scan, update and response
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr            = '0;
      alloc         = 1'b0;
      release_slot  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req;
               idx_in        = '0;
               issue_done_in = 1'b0;
               cmp_vld_in    = 1'b0;
               free_vld_in   = 1'b0;
               hit_in        = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle and note the lowest free slot
            if (!issue_done_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
               if (!free_vld_ff && !valid_ff[tbl][idx_ff]) begin
                  free_vld_in = 1'b1;
                  free_idx_in = idx_ff;
               end
            end else begin
               cmp_vld_in = 1'b0;
            end
            // Stop on a hit or after the last compare
            if (key_match) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               count_in   = rd_data.count;
               state_in   = ST_UPDATE;
            end else if (last_cmp) begin
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.found     = hit_ff;
            rsp_in.table_full = 1'b0;
            rsp_in.pin_count = '0;
            unique case (req_ff.command)
               rct_pkg::CMD_INCR: begin
                  if (hit_ff) begin
                     wr.en            = 1'b1;
                     wr.addr          = {tbl, hit_idx_ff};
                     wr.count         = incr_val;
                     rsp_in.pin_count = rct_pkg::to_pin_count(incr_val);
                  end else if (free_vld_ff) begin
                     alloc            = 1'b1;
                     wr.en            = 1'b1;
                     wr.key_en        = 1'b1;
                     wr.addr          = {tbl, free_idx_ff};
                     wr.key           = req_ff.object_address;
                     wr.count         = COUNT_ONE;
                     rsp_in.pin_count = rct_pkg::to_pin_count(COUNT_ONE);
                  end else begin
                     rsp_in.table_full = 1'b1;
                  end
               end
               rct_pkg::CMD_DECR: begin
                  if (hit_ff) begin
                     if (count_ff <= COUNT_ONE) begin
                        release_slot = 1'b1;
                     end else begin
                        wr.en            = 1'b1;
                        wr.addr          = {tbl, hit_idx_ff};
                        wr.count         = step;
                        rsp_in.pin_count = rct_pkg::to_pin_count(step);
                     end
                  end
               end
               default: begin
                  if (hit_ff) begin
                     rsp_in.pin_count = rct_pkg::to_pin_count(count_ff);
                  end
               end
            endcase
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         free_vld_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         free_vld_ff   <= free_vld_in;
         hit_ff        <= hit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_idx_ff <= free_idx_in;
      hit_idx_ff  <= hit_idx_in;
      count_ff    <= count_in;
      rsp_ff      <= rsp_in;
   end

   // Set valid on allocation, drop it when a count reaches zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= '0;
         valid_ff[1] <= '0;
      end else if (alloc) begin
         valid_ff[tbl][free_idx_ff] <= 1'b1;
      end else if (release_slot) begin
         valid_ff[tbl][hit_idx_ff] <= 1'b0;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_UPDATE))
      else $error("result strobe without a preceding update");

   a_full_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.table_full) |-> (!rsp_ff.found && rsp_ff.pin_count == '0))
      else $error("table full result carries a count or a hit");

   a_alloc_free_slot: assert property (@(posedge clock) disable iff (reset)
      alloc |-> (!valid_ff[tbl][free_idx_ff] && !hit_ff))
      else $error("allocation into an occupied slot");

   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_release_hit: assert property (@(posedge clock) disable iff (reset)
      release_slot |-> (hit_ff && valid_ff[tbl][hit_idx_ff]))
      else $error("release of a slot that was not hit");

endmodule
